// File: sv/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg: shared definitions for the line edit buffer
// Line depth, counter widths, action and result codes, key codes.
// ----------------------------------------------------------------------------
package leb_pkg;

  // line store geometry
  localparam int unsigned LINE_DEPTH = 512;
  localparam int unsigned ADDR_W     = $clog2(LINE_DEPTH);
  localparam int unsigned CNT_W      = $clog2(LINE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(LINE_DEPTH - 1);

  // input action codes
  typedef enum logic [1:0] {
    ACT_KEY  = 2'd0,
    ACT_READ = 2'd1,
    ACT_INTR = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  // result kind codes
  typedef enum logic [2:0] {
    KIND_ECHO      = 3'd0,
    KIND_DATA      = 3'd1,
    KIND_NOT_READY = 3'd2,
    KIND_INTR      = 3'd3,
    KIND_REFUSED   = 3'd4
  } kind_e;

  // key codes
  localparam logic [7:0] KEY_CR    = 8'h0D;
  localparam logic [7:0] KEY_LF    = 8'h0A;
  localparam logic [7:0] KEY_DEL   = 8'h7F;
  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_SPACE = 8'h20;

endpackage

// File: sv/leb_ram.sv
// ----------------------------------------------------------------------------
// leb_ram: generic single-write, single-read synchronous RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module leb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/line_edit_buffer.sv
// ----------------------------------------------------------------------------
// line_edit_buffer: keyboard line editor with echo
// Builds a line from key beats with echo, then drains it one byte per read.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o  | action_i, key_byte_i
//   out     | output    | out_valid_o / out_stall_i| kind_o, data_byte_o,
//           |           |                          | line_end_o, last_o
//
// An input beat is decided in the cycle it is accepted; a single-result beat
// can follow every cycle, a backspace holds the result register for three
// output beats. Read data comes from the registered read port of the line store RAM
// in the cycle after the read request is accepted, straight into the result slot.
// Reset clears counters, phase and the result slot; the store needs no clear.
// An occupied result slot stalls the input unless its final result leaves in
// that same cycle; a stalled output holds the result slot.
module line_edit_buffer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [7:0] key_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic       line_end_o,
  output logic       last_o
);

  // line state
  logic [leb_pkg::CNT_W-1:0] fill_q, fill_d;
  logic [leb_pkg::CNT_W-1:0] drain_q, drain_d;
  logic                      ready_q, ready_d;

  // result slot
  logic                      pend_valid_q, pend_valid_d;
  leb_pkg::kind_e            pend_kind_q, pend_kind_d;
  logic [7:0]                pend_data_q, pend_data_d;
  logic                      pend_end_q, pend_end_d;
  logic                      pend_ram_q, pend_ram_d;
  logic                      pend_bs_q, pend_bs_d;
  logic [1:0]                step_q, step_d;

  // store access
  logic                      ram_we;
  logic [7:0]                ram_wdata;
  logic                      ram_re;
  logic [7:0]                ram_rdata;

  logic                      in_fire;
  logic                      out_fire;
  logic                      slot_last;
  logic                      slot_free;
  logic [leb_pkg::CNT_W-1:0] drain_inc;
  leb_pkg::action_e          action;
  logic                      is_newline;
  logic                      is_erase;
  logic                      room;

  assign action     = leb_pkg::action_e'(action_i);
  assign slot_last  = !pend_bs_q || (step_q == 2'd2);
  assign out_fire   = pend_valid_q && !out_stall_i;
  assign slot_free  = !pend_valid_q || (out_fire && slot_last);
  assign in_stall_o = !slot_free;
  assign in_fire    = in_valid_i && slot_free;

  assign is_newline = (key_byte_i == leb_pkg::KEY_CR) || (key_byte_i == leb_pkg::KEY_LF);
  assign is_erase   = (key_byte_i == leb_pkg::KEY_DEL) || (key_byte_i == leb_pkg::KEY_BS);
  assign room       = fill_q < leb_pkg::FILL_MAX;
  assign drain_inc  = drain_q + leb_pkg::CNT_W'(1);

  // beat decode, state update and result slot load
  always_comb begin
    fill_d       = fill_q;
    drain_d      = drain_q;
    ready_d      = ready_q;
    pend_valid_d = pend_valid_q;
    pend_kind_d  = pend_kind_q;
    pend_data_d  = pend_data_q;
    pend_end_d   = pend_end_q;
    pend_ram_d   = pend_ram_q;
    pend_bs_d    = pend_bs_q;
    step_d       = step_q;
    ram_we       = 1'b0;
    ram_wdata    = key_byte_i;
    ram_re       = 1'b0;

    // advance or retire the slot
    if (out_fire) begin
      if (slot_last) begin
        pend_valid_d = 1'b0;
      end else begin
        step_d = step_q + 2'd1;
      end
    end

    if (in_fire) begin
      // defaults for a new single result
      pend_kind_d = leb_pkg::KIND_ECHO;
      pend_data_d = 8'h00;
      pend_end_d  = 1'b0;
      pend_ram_d  = 1'b0;
      pend_bs_d   = 1'b0;
      step_d      = 2'd0;
      case (action)
        leb_pkg::ACT_INTR: begin
          fill_d       = '0;
          drain_d      = '0;
          ready_d      = 1'b0;
          pend_valid_d = 1'b1;
          pend_kind_d  = leb_pkg::KIND_INTR;
        end
        leb_pkg::ACT_READ: begin
          pend_valid_d = 1'b1;
          if (ready_q && (drain_q < fill_q)) begin
            ram_re      = 1'b1;
            pend_kind_d = leb_pkg::KIND_DATA;
            pend_ram_d  = 1'b1;
            drain_d     = drain_inc;
            if (drain_inc >= fill_q) begin
              pend_end_d = 1'b1;
              fill_d     = '0;
              drain_d    = '0;
              ready_d    = 1'b0;
            end
          end else begin
            pend_kind_d = leb_pkg::KIND_NOT_READY;
          end
        end
        leb_pkg::ACT_KEY: begin
          if (ready_q) begin
            pend_valid_d = 1'b1;
            pend_kind_d  = leb_pkg::KIND_REFUSED;
          end else if (is_newline) begin
            if (room) begin
              ram_we    = 1'b1;
              ram_wdata = leb_pkg::KEY_LF;
              fill_d    = fill_q + leb_pkg::CNT_W'(1);
            end
            ready_d      = 1'b1;
            drain_d      = '0;
            pend_valid_d = 1'b1;
            pend_data_d  = leb_pkg::KEY_LF;
          end else if (is_erase) begin
            if (fill_q != '0) begin
              fill_d       = fill_q - leb_pkg::CNT_W'(1);
              pend_valid_d = 1'b1;
              pend_bs_d    = 1'b1;
            end
          end else if ((key_byte_i >= leb_pkg::KEY_SPACE) && room) begin
            ram_we       = 1'b1;
            fill_d       = fill_q + leb_pkg::CNT_W'(1);
            pend_valid_d = 1'b1;
            pend_data_d  = key_byte_i;
          end
        end
        default: begin
          // unused action: no result, no state change
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      drain_q      <= '0;
      ready_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_bs_q    <= 1'b0;
      step_q       <= 2'd0;
    end else begin
      fill_q       <= fill_d;
      drain_q      <= drain_d;
      ready_q      <= ready_d;
      pend_valid_q <= pend_valid_d;
      pend_bs_q    <= pend_bs_d;
      step_q       <= step_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    pend_kind_q <= pend_kind_d;
    pend_data_q <= pend_data_d;
    pend_end_q  <= pend_end_d;
    pend_ram_q  <= pend_ram_d;
  end

  // line store
  leb_ram #(
    .WIDTH (8),
    .DEPTH (leb_pkg::LINE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[leb_pkg::ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (drain_q[leb_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // output mux: backspace, space, backspace for erase
  always_comb begin
    if (pend_ram_q) begin
      data_byte_o = ram_rdata;
    end else if (pend_bs_q) begin
      data_byte_o = (step_q == 2'd1) ? leb_pkg::KEY_SPACE : leb_pkg::KEY_BS;
    end else begin
      data_byte_o = pend_data_q;
    end
  end

  assign out_valid_o = pend_valid_q;
  assign kind_o      = pend_kind_q;
  assign line_end_o  = pend_end_q;
  assign last_o      = slot_last;

endmodule
